// ===== rtl/acs_pkg.sv =====
`default_nettype none

package acs_pkg;

   localparam int BYTE_W      = 8;
   localparam int NEST_MAX    = 255;
   localparam int PENDING_MAX = 60;
   localparam int DEPTH_W     = $clog2(NEST_MAX + 1);
   localparam int PEND_W      = $clog2(PENDING_MAX + 1);
   // a newline run is the queued joins plus the real newline
   localparam int CNT_W       = $clog2(PENDING_MAX + 2);

   // plan queue, depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

   typedef enum logic [1:0] {
      STR_NONE,
      STR_DOUBLE,
      STR_SINGLE
   } str_mode_type;

   typedef enum logic [1:0] {
      SEG_NONE,
      SEG_BYTE,
      SEG_NEWLINES
   } seg_kind_type;

   typedef struct packed {
      str_mode_type       mode;
      logic               escape;
      logic               in_line;
      logic [DEPTH_W-1:0] depth;
      logic               skip;
   } strip_state_type;

   typedef struct packed {
      logic              pending;
      logic [PEND_W-1:0] pend;
   } join_state_type;

   // output of the join step for one stripped byte
   typedef struct packed {
      logic              bslash;
      seg_kind_type      kind;
      logic [BYTE_W-1:0] data;
      logic [CNT_W-1:0]  count;
   } seg_type;

   // everything one request emits, in order
   typedef struct packed {
      seg_type first;
      seg_type second;
      logic    tail_bslash;
   } plan_type;

endpackage

`default_nettype wire

// ===== rtl/acs_ifs.sv =====
`default_nettype none

interface acs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface acs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface acs_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_comment_char;
   modport source (output valid, output line_comment_char, input ready);
   modport sink (input valid, input line_comment_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/acs_front.sv =====
`default_nettype none

module acs_front import acs_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   acs_req_if.sink    req,
   acs_csr_if.sink    csr,
   input  wire        queue_full,
   output logic       push_valid,
   output plan_type   push_plan
);

   typedef struct packed {
      strip_state_type   st;
      logic [BYTE_W-1:0] data;
   } strip_res_type;

   typedef struct packed {
      join_state_type st;
      seg_type        seg;
   } join_res_type;

   function automatic strip_res_type strip_step(
      input strip_state_type   s,
      input logic [BYTE_W-1:0] c,
      input logic              has_next,
      input logic [BYTE_W-1:0] nx,
      input logic [BYTE_W-1:0] lcc
   );
      strip_res_type r;
      r.st   = s;
      r.data = c;
      if (s.skip) begin
         r.st.skip = 1'b0;
         r.data    = CH_SPACE;
      end else begin
         // string tracking only outside comments
         if (!s.in_line && s.depth == '0) begin
            if (c == CH_BSLASH) begin
               r.st.escape = (s.mode != STR_NONE) ? !s.escape : 1'b0;
            end else begin
               if (c == CH_DQUOTE) begin
                  if (s.mode == STR_NONE) r.st.mode = STR_DOUBLE;
                  else if (s.mode == STR_DOUBLE && !s.escape) r.st.mode = STR_NONE;
               end else if (c == CH_SQUOTE) begin
                  if (s.mode == STR_NONE) r.st.mode = STR_SINGLE;
                  else if (s.mode == STR_SINGLE && !s.escape) r.st.mode = STR_NONE;
               end else if (c == CH_LF) begin
                  r.st.mode = STR_NONE;
               end
               r.st.escape = 1'b0;
            end
         end
         if (r.st.mode != STR_NONE) begin
            r.data = c;
         end else if (has_next && !s.in_line && c == CH_SLASH && nx == CH_STAR) begin
            if (s.depth < DEPTH_W'(NEST_MAX)) r.st.depth = s.depth + DEPTH_W'(1);
            r.st.skip = 1'b1;
            r.data    = CH_SPACE;
         end else if (has_next && s.depth != '0 && c == CH_STAR && nx == CH_SLASH) begin
            r.st.depth = s.depth - DEPTH_W'(1);
            r.st.skip  = 1'b1;
            r.data     = CH_SPACE;
         end else if (s.in_line || s.depth != '0) begin
            if (c == CH_LF) begin
               r.st.in_line = 1'b0;
               r.data       = c;
            end else begin
               r.data = CH_SPACE;
            end
         end else if (c == lcc) begin
            r.st.in_line = 1'b1;
            r.data       = CH_SPACE;
         end else begin
            r.data = c;
         end
      end
      return r;
   endfunction

   function automatic join_res_type join_step(
      input join_state_type    j,
      input logic [BYTE_W-1:0] o
   );
      join_res_type r;
      logic         go;
      r.st         = j;
      r.seg.bslash = 1'b0;
      r.seg.kind   = SEG_NONE;
      r.seg.data   = o;
      r.seg.count  = '0;
      go           = 1'b1;
      if (j.pending) begin
         if (o == CH_CR) begin
            go = 1'b0;
         end else if (o == CH_LF) begin
            if (j.pend < PEND_W'(PENDING_MAX)) r.st.pend = j.pend + PEND_W'(1);
            r.st.pending = 1'b0;
            go           = 1'b0;
         end else begin
            r.seg.bslash = 1'b1;
            r.st.pending = 1'b0;
         end
      end
      if (go) begin
         if (o == CH_BSLASH) begin
            r.st.pending = 1'b1;
         end else if (o == CH_CR) begin
            r.seg.kind = SEG_NONE;
         end else if (o == CH_LF) begin
            r.seg.kind  = SEG_NEWLINES;
            r.seg.count = CNT_W'(r.st.pend) + CNT_W'(1);
            r.st.pend   = '0;
         end else begin
            r.seg.kind = SEG_BYTE;
         end
      end
      return r;
   endfunction

   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   strip_state_type   strip_ff, strip_in;
   join_state_type    join_ff, join_in;
   logic [BYTE_W-1:0] lcc_ff, lcc_in;

   strip_res_type     strip_held, strip_new;
   join_res_type      join_held, join_new;
   strip_state_type   strip_mid;
   join_state_type    join_mid;
   seg_type           seg_none;
   logic              accept;

   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   always_comb begin
      seg_none.bslash = 1'b0;
      seg_none.kind   = SEG_NONE;
      seg_none.data   = CH_NUL;
      seg_none.count  = '0;

      // held byte with the new one as lookahead
      strip_held = strip_step(strip_ff, held_byte_ff, 1'b1, req.text_byte, lcc_ff);
      join_held  = join_step(join_ff, strip_held.data);
      strip_mid  = held_valid_ff ? strip_held.st : strip_ff;
      join_mid   = held_valid_ff ? join_held.st : join_ff;

      // new byte without lookahead, used only on end of text
      strip_new = strip_step(strip_mid, req.text_byte, 1'b0, CH_NUL, lcc_ff);
      join_new  = join_step(join_mid, strip_new.data);

      push_plan.first       = held_valid_ff ? join_held.seg : seg_none;
      push_plan.second      = req.end_of_text ? join_new.seg : seg_none;
      push_plan.tail_bslash = req.end_of_text && join_new.st.pending;

      push_valid = accept &&
                   (push_plan.first.bslash || push_plan.first.kind != SEG_NONE ||
                    push_plan.second.bslash || push_plan.second.kind != SEG_NONE ||
                    push_plan.tail_bslash);

      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      strip_in      = strip_ff;
      join_in       = join_ff;
      if (accept) begin
         if (req.end_of_text) begin
            held_byte_in  = CH_NUL;
            held_valid_in = 1'b0;
            strip_in      = '0;
            join_in       = '0;
         end else begin
            held_byte_in  = req.text_byte;
            held_valid_in = 1'b1;
            strip_in      = strip_mid;
            join_in       = join_mid;
         end
      end

      lcc_in = (csr.valid && csr.ready) ? csr.line_comment_char : lcc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         strip_ff      <= '0;
         join_ff       <= '0;
         lcc_ff        <= CH_SEMI;
      end else begin
         held_valid_ff <= held_valid_in;
         strip_ff      <= strip_in;
         join_ff       <= join_in;
         lcc_ff        <= lcc_in;
      end
      held_byte_ff <= held_byte_in;
   end

   // end of text leaves nothing behind for the next text
   assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_text |=> !held_valid_ff && !join_ff.pending && join_ff.pend == '0)
      else $error("state not cleared after end of text");

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("plan pushed into full queue");

endmodule

`default_nettype wire

// ===== rtl/acs_plan_queue.sv =====
`default_nettype none

module acs_plan_queue import acs_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        push_valid,
   input  plan_type   push_plan,
   output logic       full,
   output logic       head_valid,
   output plan_type   head_plan,
   input  wire        pop
);

   plan_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_plan  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) count_in = count_ff + QCNT_W'(1);
      else if (!push_valid && pop) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) entries_ff[wr_ptr_ff] <= push_plan;
   end

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty plan queue");

endmodule

`default_nettype wire

// ===== rtl/acs_back.sv =====
`default_nettype none

module acs_back import acs_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        head_valid,
   input  plan_type   head_plan,
   output logic       pop,
   acs_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      SL_BS1,
      SL_MAIN1,
      SL_BS2,
      SL_MAIN2,
      SL_TAIL
   } slot_type;

   localparam int NSLOT = 5;

   slot_type          slot_ff;
   logic [CNT_W-1:0]  nl_done_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;

   logic [NSLOT-1:0]  slot_ne;
   logic [NSLOT-1:0]  slot_nl;
   logic [BYTE_W-1:0] slot_byte [NSLOT];
   logic [CNT_W-1:0]  slot_cnt [NSLOT];
   logic [2:0]        cur_idx;
   logic              found;
   logic              more_here;
   logic              later;
   logic              last;
   logic              advance;

   always_comb begin
      slot_ne[0] = head_plan.first.bslash;
      slot_ne[1] = head_plan.first.kind != SEG_NONE;
      slot_ne[2] = head_plan.second.bslash;
      slot_ne[3] = head_plan.second.kind != SEG_NONE;
      slot_ne[4] = head_plan.tail_bslash;

      slot_nl[0] = 1'b0;
      slot_nl[1] = head_plan.first.kind == SEG_NEWLINES;
      slot_nl[2] = 1'b0;
      slot_nl[3] = head_plan.second.kind == SEG_NEWLINES;
      slot_nl[4] = 1'b0;

      slot_byte[0] = CH_BSLASH;
      slot_byte[1] = slot_nl[1] ? CH_LF : head_plan.first.data;
      slot_byte[2] = CH_BSLASH;
      slot_byte[3] = slot_nl[3] ? CH_LF : head_plan.second.data;
      slot_byte[4] = CH_BSLASH;

      slot_cnt[0] = CNT_W'(1);
      slot_cnt[1] = slot_nl[1] ? head_plan.first.count : CNT_W'(1);
      slot_cnt[2] = CNT_W'(1);
      slot_cnt[3] = slot_nl[3] ? head_plan.second.count : CNT_W'(1);
      slot_cnt[4] = CNT_W'(1);

      // first slot at or after the current one that still has output
      cur_idx = 3'(NSLOT - 1);
      found   = 1'b0;
      for (int k = 0; k < NSLOT; k++) begin
         if (!found && 3'(k) >= slot_ff && slot_ne[k]) begin
            cur_idx = 3'(k);
            found   = 1'b1;
         end
      end

      more_here = slot_nl[cur_idx] && (nl_done_ff + CNT_W'(1) < slot_cnt[cur_idx]);
      later     = 1'b0;
      for (int k = 0; k < NSLOT; k++) begin
         if (3'(k) > cur_idx && slot_ne[k]) later = 1'b1;
      end
      last = !more_here && !later;

      advance = head_valid && (!rsp_valid_ff || rsp.ready);
      pop     = advance && last;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = rsp_byte_ff;
   assign rsp.last_of_run = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SL_BS1;
         nl_done_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         rsp_byte_ff  <= slot_byte[cur_idx];
         rsp_last_ff  <= last;
         if (more_here) begin
            slot_ff    <= slot_type'(cur_idx);
            nl_done_ff <= nl_done_ff + CNT_W'(1);
         end else if (last) begin
            slot_ff    <= SL_BS1;
            nl_done_ff <= '0;
         end else begin
            slot_ff    <= slot_type'(cur_idx + 3'd1);
            nl_done_ff <= '0;
         end
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // only a newline run can be part-way done
   assert property (@(posedge clock) disable iff (reset)
      nl_done_ff != '0 |-> slot_ff == SL_MAIN1 || slot_ff == SL_MAIN2)
      else $error("partial run outside a main slot");

   // a plan in the queue always has something left to emit
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> found)
      else $error("queued plan with nothing to emit");

endmodule

`default_nettype wire

// ===== rtl/asm_comment_stripper_top.sv =====
`default_nettype none

// channel   port      dir  payload
// request   req_bus   in   text_byte[7:0], end_of_text
// result    rsp_bus   out  out_byte[7:0], last_of_run
// config    csr_bus   in   line_comment_char[7:0]
//
// one request accepted per cycle while the plan queue (4 entries) has room
// results leave one per cycle while rsp_bus is ready; the back end finishes every result of a request before the next,
//   a newline run after line joins giving one result per newline
// first result of a request is registered in the plan queue, then in the back end output register, before rsp_bus
// reset is synchronous; it clears all tracking state and sets the comment char to ';'
// a stalled rsp_bus backs up into the queue, then req_bus.ready drops
module asm_comment_stripper_top import acs_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   acs_req_if.sink    req_bus,
   acs_rsp_if.source  rsp_bus,
   acs_csr_if.sink    csr_bus
);

   // front end: string and comment tracking plus line-join folding, one request a cycle while the queue has room
   logic     push_valid;
   plan_type push_plan;
   logic     queue_full;

   // back end side of the queue
   logic     head_valid;
   plan_type head_plan;
   logic     pop;

   acs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_plan  (push_plan)
   );

   // requests that emit nothing never enter the queue
   acs_plan_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_plan  (push_plan),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_plan  (head_plan),
      .pop        (pop)
   );

   // back end: walks each plan slot by slot into the output register
   acs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_plan  (head_plan),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire
